FILE: design/fibmp_pkg.sv
package fibmp_pkg;

    localparam int WORD_W = 64;
    localparam int HALF_W = 32;
    localparam int EXP_W  = WORD_W - 1;
    localparam int TERM_W = 3;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [HALF_W-1:0] half_t;

    // entries a, b, c, d of a 2x2 matrix, row-major
    typedef logic [3:0][WORD_W-1:0] mat2_t;

    localparam logic [1:0] ENT_A = 2'd0;
    localparam logic [1:0] ENT_B = 2'd1;
    localparam logic [1:0] ENT_C = 2'd2;
    localparam logic [1:0] ENT_D = 2'd3;

    // packed concatenation lists d first, a last
    localparam mat2_t BASE_MATRIX     = {64'd1, 64'd1, 64'd1, 64'd2};
    localparam mat2_t IDENTITY_MATRIX = {64'd1, 64'd0, 64'd0, 64'd1};

    // eight product terms per matrix product, then the multiply pipe is drained
    localparam logic [TERM_W-1:0] TERM_LAST  = 3'd7;
    localparam logic [TERM_W-1:0] DRAIN_LAST = 3'd1;

    typedef enum logic {
        OP_MUL = 1'b0,
        OP_SQR = 1'b1
    } op_t;

    typedef struct packed {
        logic              load;
        logic              issue;
        logic [TERM_W-1:0] term;
        logic              commit;
        op_t               op;
        logic              shift;
        logic              finish;
    } dp_cmd_t;

    typedef struct packed {
        logic exp_zero;
        logic exp_lsb;
        logic exp_last;
        logic out_hold;
    } dp_status_t;

endpackage

FILE: design/fibmp_datapath.sv
module fibmp_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  fibmp_pkg::dp_cmd_t   cmd,
    output fibmp_pkg::dp_status_t status,
    input  fibmp_pkg::word_t     index,
    input  logic                 out_ready,
    output logic                 out_valid,
    output fibmp_pkg::word_t     fib_value
);
    import fibmp_pkg::*;

    mat2_t            m_reg;
    mat2_t            acc_reg;
    mat2_t            r_reg;
    logic [EXP_W-1:0] exp_reg;
    logic             odd_reg;

    // multiply stage
    logic             s1_valid_reg;
    logic [1:0]       s1_entry_reg;
    logic             s1_half_reg;
    word_t            s1_ll_reg;
    half_t            s1_lh_reg;
    half_t            s1_hl_reg;

    // product stage
    logic             s2_valid_reg;
    logic [1:0]       s2_entry_reg;
    logic             s2_half_reg;
    word_t            s2_prod_reg;

    logic             out_valid_reg;
    word_t            out_data_reg;

    mat2_t            x_mat;
    word_t            x_word;
    word_t            y_word;
    word_t            ll_next;
    half_t            lh_next;
    half_t            hl_next;
    half_t            cross_sum;
    word_t            prod_next;

    // term k: entry (i,j) = k[2:1], half h = k[0]; adds X[i][h] * M[h][j]
    assign x_mat   = (cmd.op == OP_SQR) ? m_reg : acc_reg;
    assign x_word  = x_mat[{cmd.term[2], cmd.term[0]}];
    assign y_word  = m_reg[{cmd.term[0], cmd.term[1]}];

    // low 64 bits of a 64x64 product from three 32x32 partials
    assign ll_next = x_word[HALF_W-1:0] * y_word[HALF_W-1:0];
    assign lh_next = x_word[HALF_W-1:0] * y_word[WORD_W-1:HALF_W];
    assign hl_next = x_word[WORD_W-1:HALF_W] * y_word[HALF_W-1:0];

    assign cross_sum = s1_lh_reg + s1_hl_reg;
    assign prod_next = s1_ll_reg + {cross_sum, {HALF_W{1'b0}}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd.issue;
            s2_valid_reg <= s1_valid_reg;
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            m_reg   <= BASE_MATRIX;
            acc_reg <= IDENTITY_MATRIX;
            exp_reg <= index[WORD_W-1:1];
            odd_reg <= index[0];
        end
        else
        begin
            if (cmd.commit)
            begin
                if (cmd.op == OP_SQR)
                begin
                    m_reg <= r_reg;
                end
                else
                begin
                    acc_reg <= r_reg;
                end
            end
            if (cmd.shift)
            begin
                exp_reg <= exp_reg >> 1;
            end
        end

        s1_entry_reg <= cmd.term[2:1];
        s1_half_reg  <= cmd.term[0];
        s1_ll_reg    <= ll_next;
        s1_lh_reg    <= lh_next;
        s1_hl_reg    <= hl_next;

        s2_entry_reg <= s1_entry_reg;
        s2_half_reg  <= s1_half_reg;
        s2_prod_reg  <= prod_next;

        if (s2_valid_reg)
        begin
            if (s2_half_reg)
            begin
                r_reg[s2_entry_reg] <= r_reg[s2_entry_reg] + s2_prod_reg;
            end
            else
            begin
                r_reg[s2_entry_reg] <= s2_prod_reg;
            end
        end

        if (cmd.finish)
        begin
            out_data_reg <= odd_reg ? acc_reg[ENT_A] : acc_reg[ENT_C];
        end
    end

    assign status.exp_zero = (exp_reg == '0);
    assign status.exp_lsb  = exp_reg[0];
    assign status.exp_last = (exp_reg[EXP_W-1:1] == '0);
    assign status.out_hold = out_valid_reg & ~out_ready;

    assign out_valid = out_valid_reg;
    assign fib_value = out_data_reg;

endmodule

FILE: design/fibmp_ctrl.sv
module fibmp_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  fibmp_pkg::dp_status_t status,
    output fibmp_pkg::dp_cmd_t    cmd
);
    import fibmp_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_CHECK  = 7'b0000010,
        ST_ISSUE  = 7'b0000100,
        ST_DRAIN  = 7'b0001000,
        ST_COMMIT = 7'b0010000,
        ST_SHIFT  = 7'b0100000,
        ST_FINISH = 7'b1000000
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [TERM_W-1:0] cnt_reg;
    logic [TERM_W-1:0] cnt_next;
    op_t               op_reg;
    op_t               op_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            op_reg    <= OP_MUL;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            op_reg    <= op_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        op_next    = op_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.op     = op_reg;
        cmd.term   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                // index 0 and 1 leave the exponent at zero: identity gives the answer
                if (status.exp_zero)
                begin
                    state_next = ST_FINISH;
                end
                else if (status.exp_lsb)
                begin
                    op_next    = OP_MUL;
                    cnt_next   = '0;
                    state_next = ST_ISSUE;
                end
                else
                begin
                    state_next = ST_SHIFT;
                end
            end
            ST_ISSUE:
            begin
                cmd.issue = 1'b1;
                if (cnt_reg == TERM_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (cnt_reg == DRAIN_LAST)
                begin
                    state_next = ST_COMMIT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = (op_reg == OP_MUL) ? ST_SHIFT : ST_CHECK;
            end
            ST_SHIFT:
            begin
                cmd.shift = 1'b1;
                // no squaring once the last exponent bit is used
                if (status.exp_last)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    op_next    = OP_SQR;
                    cnt_next   = '0;
                    state_next = ST_ISSUE;
                end
            end
            ST_FINISH:
            begin
                if (!status.out_hold)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: design/fibonacci_by_matrix_power.sv
// sequence: check the index; over the bits of index/2, a multiply for each one bit,
// a shift for every bit and a squaring after every bit but the top one
// (each squaring or multiply: 8 product terms issued, the pipe drained, 1 write-back)
// throughput: one request at a time; a new one is taken while the last result waits
// each 2x2 product streams 8 terms through one 64-bit modular multiply pipeline
// reset: rst_n asynchronous active low, returns to idle with no result pending
module fibonacci_by_matrix_power (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  fibmp_pkg::word_t        index,
    output logic                    out_valid,
    input  logic                    out_ready,
    output fibmp_pkg::word_t        fib_value
);
    import fibmp_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    fibmp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    fibmp_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .index     (index),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .fib_value (fib_value)
    );

    // one request in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while busy");

    // a held result is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !status.out_hold)
        else $error("result overwritten before taken");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid)
        else $error("finished result not presented");

    // write-back only after the multiply pipe has drained
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !$past(cmd.issue) && !$past(cmd.issue, 2))
        else $error("write-back before pipe drained");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

    import fibmp_pkg::*;

    localparam int RANDOM_COUNT = 1530;
    localparam int MAX_GAP      = 11;
    localparam int DRAIN_CYCLES = 40;

    localparam word_t DIRECTED [18] = '{
        64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd5, 64'd6,
        // F(93) is the largest value that fits, F(94) is the first that wraps
        64'd93, 64'd94, 64'd95,
        64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE,
        64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001,
        64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
        64'h0000_0001_0000_0000, 64'h0000_0000_FFFF_FFFF
    };

    class fib_scoreboard;
        word_t expected_fib[$];
        int    errors;

        function mat2_t mat_product(mat2_t x, mat2_t y);
            mat2_t r;
            r[ENT_A] = x[ENT_A] * y[ENT_A] + x[ENT_B] * y[ENT_C];
            r[ENT_B] = x[ENT_A] * y[ENT_B] + x[ENT_B] * y[ENT_D];
            r[ENT_C] = x[ENT_C] * y[ENT_A] + x[ENT_D] * y[ENT_C];
            r[ENT_D] = x[ENT_C] * y[ENT_B] + x[ENT_D] * y[ENT_D];
            return r;
        endfunction

        // F(n) mod 2^64 from [[2,1],[1,1]] raised to n/2
        function word_t fib_mod64(word_t n);
            mat2_t acc;
            mat2_t sq;
            word_t e;
            if (n == 64'd0)
                return 64'd0;
            if (n == 64'd1)
                return 64'd1;
            acc[ENT_A] = 64'd1;
            acc[ENT_B] = 64'd0;
            acc[ENT_C] = 64'd0;
            acc[ENT_D] = 64'd1;
            sq[ENT_A]  = 64'd2;
            sq[ENT_B]  = 64'd1;
            sq[ENT_C]  = 64'd1;
            sq[ENT_D]  = 64'd1;
            e = n >> 1;
            while (e != 64'd0)
            begin
                if (e[0])
                    acc = mat_product(acc, sq);
                e = e >> 1;
                if (e != 64'd0)
                    sq = mat_product(sq, sq);
            end
            return n[0] ? acc[ENT_A] : acc[ENT_C];
        endfunction

        function void note_request(word_t n);
            expected_fib.push_back(fib_mod64(n));
        endfunction

        function void check_result(word_t value);
            word_t want;
            if (expected_fib.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result %h with no request pending", value);
                return;
            end
            want = expected_fib.pop_front();
            if (value !== want)
            begin
                errors++;
                if (errors <= 10)
                    $display("fib_value mismatch: expected %h, got %h", want, value);
            end
        endfunction

        function int pending();
            return expected_fib.size();
        endfunction
    endclass

    logic  clk       = 1'b0;
    logic  rst_n     = 1'b0;
    logic  in_valid  = 1'b0;
    logic  in_ready;
    word_t index     = '0;
    logic  out_valid;
    logic  out_ready = 1'b0;
    word_t fib_value;

    fib_scoreboard sb = new;
    bit calm_in  = 1'b0;
    bit calm_out = 1'b0;

    fibonacci_by_matrix_power u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .index     (index),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .fib_value (fib_value)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_index(input word_t n);
        int gap;
        gap = calm_in ? 0 : $urandom_range(MAX_GAP);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        index    = n;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_request(n);
        @(negedge clk);
    endtask

    // most indices short so the run stays bounded; a tenth use all 64 bits
    function automatic word_t random_index();
        int    sel;
        int    bits;
        word_t v;
        sel = $urandom_range(99);
        v   = {$urandom, $urandom};
        if (sel < 5)
            return word_t'($urandom_range(5));
        if (sel < 70)
            bits = $urandom_range(16, 2);
        else if (sel < 90)
            bits = $urandom_range(40, 17);
        else
            bits = 64;
        if (bits < 64)
            v = v & ((64'd1 << bits) - 64'd1);
        return v;
    endfunction

    // result side
    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            stall = calm_out ? 0 : $urandom_range(MAX_GAP);
            if (stall > 0)
            begin
                out_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready = 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            sb.check_result(fib_value);
            @(negedge clk);
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (DIRECTED[i])
            send_index(DIRECTED[i]);

        for (int i = 0; i < RANDOM_COUNT; i++)
        begin
            // alternate stretches of back-to-back traffic with random gaps
            if (i % 64 == 0)
            begin
                calm_in  = ($urandom_range(3) == 0);
                calm_out = ($urandom_range(3) == 0);
            end
            send_index(random_index());
        end
        in_valid = 1'b0;
        calm_out = 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #200_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
